>>> hdl/spimbe_pkg.sv
package spimbe_pkg;

    localparam int DATA_BITS_DEF  = 8;
    localparam int WAIT_WIDTH_DEF = 16;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_IDX_W  = 3;

    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;

    localparam int BYTE_W = 8;
    localparam int TICK_W = 16;

    typedef enum logic [IN_USER_W-1:0] {
        KIND_TICK    = 2'd0,
        KIND_START   = 2'd1,
        KIND_SELECT  = 2'd2,
        KIND_RELEASE = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CPOL          = 3'd0,
        REG_CPHA          = 3'd1,
        REG_LSB_FIRST     = 3'd2,
        REG_CS_ACTIVE_LOW = 3'd3,
        REG_AUTO_CS       = 3'd4,
        REG_LOW_TICKS     = 3'd5,
        REG_HIGH_TICKS    = 3'd6,
        REG_UNUSED        = 3'd7
    } t_reg_idx;

    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_MIDDLE = 2'd1;
    localparam logic [1:0] PHASE_LAST   = 2'd2;

endpackage

>>> hdl/spi_master_bit_engine.sv
// SPI master bit engine. Every item on the slave stream is one tick of the
// serial clock generator; it returns exactly one result item on the master
// stream holding the pin levels after that tick.
//   s_axis: tdata = {miso, tx_byte}, tuser = kind, tlast = last_in_burst.
//   m_axis: tdata = sck, mosi, cs_pin, rx_valid, rx_byte, busy, accepted.
//   APB: cpol, cpha, lsb_first, cs_active_low, auto_cs, low_ticks,
//   high_ticks at byte addresses 0, 4, ... 24; write only while idle.
// An item's result is registered and is on m_axis in the cycle after acceptance.
// Throughput: one item per cycle while the receiver takes results. The whole
// tick (phase counter, shift registers, pin levels) is computed combinationally
// into the state registers and the result register.
// s_axis_tready stays high while the result register is empty or being
// taken; when the receiver stalls, the held result blocks new items.
// A byte takes DATA_BITS*(3 + 2*low_ticks + high_ticks) items with cpha 0,
// DATA_BITS*(3 + low_ticks + 2*high_ticks) with cpha 1, and one more item,
// the start item that begins it; each phase of value v lasts v+1 ticks.
// Reset (synchronous, active low) clears the engine, deselects chip
// select and empties the result register.
module spi_master_bit_engine
    import spimbe_pkg::*;
#(
    parameter int DATA_BITS  = DATA_BITS_DEF,
    parameter int WAIT_WIDTH = WAIT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // tx_byte[7:0], miso[8], zero pad
    input  logic [IN_USER_W-1:0]  s_axis_tuser,  // kind[1:0]
    input  logic                  s_axis_tlast,  // last_in_burst

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // sck[0], mosi[1], cs_pin[2],
                                                 // rx_valid[3], rx_byte[11:4],
                                                 // busy_res[12], accepted[13], pad

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IW = $clog2(DATA_BITS);
    localparam logic [IW-1:0] LAST_IDX = IW'(DATA_BITS - 1);

    // configuration
    logic              r_cpol, r_cpha, r_lsb_first, r_cs_active_low, r_auto_cs;
    logic [TICK_W-1:0] r_low_ticks, r_high_ticks;

    // engine state
    logic [DATA_BITS-1:0]  r_out_shift, n_out_shift;
    logic [DATA_BITS-1:0]  r_in_shift, n_in_shift;
    logic [IW-1:0]         r_bit_index, n_bit_index;
    logic [1:0]            r_bit_phase, n_bit_phase;
    logic [WAIT_WIDTH-1:0] r_wait, n_wait;
    logic                  r_shifting, n_shifting;
    logic                  r_cs_asserted, n_cs_asserted;
    logic                  r_release_after, n_release_after;
    logic                  r_sck, n_sck;
    logic                  r_mosi, n_mosi;

    // result register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic                  in_fire;
    logic                  cfg_wr;
    t_reg_idx              cfg_idx;
    t_kind                 kind;
    logic [BYTE_W-1:0]     tx_byte;
    logic                  miso;
    logic                  done, acc, enter;
    logic [IW-1:0]         pos;
    logic [BYTE_W-1:0]     rx_byte;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    assign kind    = t_kind'(s_axis_tuser);
    assign tx_byte = s_axis_tdata[BYTE_W-1:0];
    assign miso    = s_axis_tdata[BYTE_W];

    always_comb begin
        unique case (cfg_idx)
            REG_CPOL:          prdata = CFG_DATA_W'(r_cpol);
            REG_CPHA:          prdata = CFG_DATA_W'(r_cpha);
            REG_LSB_FIRST:     prdata = CFG_DATA_W'(r_lsb_first);
            REG_CS_ACTIVE_LOW: prdata = CFG_DATA_W'(r_cs_active_low);
            REG_AUTO_CS:       prdata = CFG_DATA_W'(r_auto_cs);
            REG_LOW_TICKS:     prdata = CFG_DATA_W'(r_low_ticks);
            REG_HIGH_TICKS:    prdata = CFG_DATA_W'(r_high_ticks);
            default:           prdata = '0;
        endcase
    end

    // one tick of the engine
    always_comb begin
        n_out_shift     = r_out_shift;
        n_in_shift      = r_in_shift;
        n_bit_index     = r_bit_index;
        n_bit_phase     = r_bit_phase;
        n_wait          = r_wait;
        n_shifting      = r_shifting;
        n_cs_asserted   = r_cs_asserted;
        n_release_after = r_release_after;
        n_sck           = r_sck;
        n_mosi          = r_mosi;
        done            = 1'b0;
        acc             = 1'b0;
        enter           = 1'b0;

        pos = r_lsb_first ? r_bit_index : LAST_IDX - r_bit_index;

        if (r_shifting) begin
            if (r_wait != '0) begin
                n_wait = r_wait - 1'b1;
            end else begin
                if (r_bit_phase == PHASE_MIDDLE && !r_cpha) begin
                    n_in_shift[pos] = r_in_shift[pos] | miso;
                end
                if (r_bit_phase != PHASE_LAST) begin
                    n_bit_phase = r_bit_phase + 1'b1;
                    enter       = 1'b1;
                end else if (r_bit_index >= LAST_IDX) begin
                    n_shifting  = 1'b0;
                    n_sck       = r_cpol;
                    n_bit_phase = PHASE_FIRST;
                    if (r_auto_cs && r_release_after) begin
                        n_cs_asserted = 1'b0;
                    end
                    n_release_after = 1'b0;
                    done            = 1'b1;
                end else begin
                    n_bit_index = r_bit_index + 1'b1;
                    n_bit_phase = PHASE_FIRST;
                    enter       = 1'b1;
                end
            end
        end else begin
            case (kind)
                KIND_START: begin
                    acc = 1'b1;
                    if (r_auto_cs) begin
                        n_cs_asserted = 1'b1;
                    end
                    n_release_after = s_axis_tlast;
                    n_out_shift     = DATA_BITS'(tx_byte);
                    n_in_shift      = '0;
                    n_bit_index     = '0;
                    n_bit_phase     = PHASE_FIRST;
                    n_shifting      = 1'b1;
                    enter           = 1'b1;
                end
                KIND_SELECT: begin
                    acc           = 1'b1;
                    n_cs_asserted = 1'b1;
                end
                KIND_RELEASE: begin
                    acc           = 1'b1;
                    n_cs_asserted = 1'b0;
                end
                default: ;
            endcase
        end

        // phase entry, on the updated bit index and phase
        pos = r_lsb_first ? n_bit_index : LAST_IDX - n_bit_index;
        if (enter) begin
            if (!r_cpha) begin
                case (n_bit_phase)
                    PHASE_FIRST: begin
                        n_sck  = r_cpol;
                        n_mosi = n_out_shift[pos];
                        n_wait = WAIT_WIDTH'(r_low_ticks);
                    end
                    PHASE_MIDDLE: begin
                        n_sck  = !r_cpol;
                        n_wait = WAIT_WIDTH'(r_high_ticks);
                    end
                    default: begin
                        n_sck  = r_cpol;
                        n_wait = WAIT_WIDTH'(r_low_ticks);
                    end
                endcase
            end else begin
                case (n_bit_phase)
                    PHASE_FIRST: begin
                        n_sck  = !r_cpol;
                        n_wait = WAIT_WIDTH'(r_high_ticks);
                    end
                    PHASE_MIDDLE: begin
                        n_mosi = n_out_shift[pos];
                        n_wait = WAIT_WIDTH'(r_low_ticks);
                    end
                    default: begin
                        n_sck           = r_cpol;
                        n_in_shift[pos] = n_in_shift[pos] | miso;
                        n_wait          = WAIT_WIDTH'(r_high_ticks);
                    end
                endcase
            end
        end

        rx_byte    = done ? BYTE_W'(n_in_shift) : '0;
        n_out_data = OUT_DATA_W'({acc, n_shifting, rx_byte, done,
                                  n_cs_asserted ^ r_cs_active_low, n_mosi, n_sck});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpol          <= 1'b0;
            r_cpha          <= 1'b0;
            r_lsb_first     <= 1'b0;
            r_cs_active_low <= 1'b1;
            r_auto_cs       <= 1'b0;
            r_low_ticks     <= '0;
            r_high_ticks    <= '0;
            r_out_shift     <= '0;
            r_in_shift      <= '0;
            r_bit_index     <= '0;
            r_bit_phase     <= PHASE_FIRST;
            r_wait          <= '0;
            r_shifting      <= 1'b0;
            r_cs_asserted   <= 1'b0;
            r_release_after <= 1'b0;
            r_sck           <= 1'b0;
            r_mosi          <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_CPOL: begin
                        r_cpol <= pwdata[0];
                        if (!r_shifting) begin
                            r_sck <= pwdata[0];
                        end
                    end
                    REG_CPHA:      r_cpha      <= pwdata[0];
                    REG_LSB_FIRST: r_lsb_first <= pwdata[0];
                    REG_CS_ACTIVE_LOW: begin
                        r_cs_active_low <= pwdata[0];
                        r_cs_asserted   <= 1'b0;
                    end
                    REG_AUTO_CS:    r_auto_cs    <= pwdata[0];
                    REG_LOW_TICKS:  r_low_ticks  <= TICK_W'(WAIT_WIDTH'(pwdata[TICK_W-1:0]));
                    REG_HIGH_TICKS: r_high_ticks <= TICK_W'(WAIT_WIDTH'(pwdata[TICK_W-1:0]));
                    default: ;
                endcase
            end else if (in_fire) begin
                r_out_shift     <= n_out_shift;
                r_in_shift      <= n_in_shift;
                r_bit_index     <= n_bit_index;
                r_bit_phase     <= n_bit_phase;
                r_wait          <= n_wait;
                r_shifting      <= n_shifting;
                r_cs_asserted   <= n_cs_asserted;
                r_release_after <= n_release_after;
                r_sck           <= n_sck;
                r_mosi          <= n_mosi;
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_data <= n_out_data;
        end
    end

endmodule
